FILE: hdl/fifo_page_replacement_unit_macros.svh
// assertion macros for the fifo page replacement unit
// sampled on clk, disabled while rst is high; no other dependencies
`ifndef FIFO_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication
`define FPRU_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPRU_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/fpru_pkg.sv
// types, codes and default sizes for the fifo page replacement unit
// no dependencies
package fpru_pkg;

  localparam int PAGES_DEF  = 64;
  localparam int FRAMES_DEF = 16;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_W      = 7;

  localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 7'd64;
  localparam logic             CMD_PUSH         = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_FREE     = 3'd1,
    STAT_REPLACED = 3'd2,
    STAT_NO_FRAME = 3'd3,
    STAT_PUSHED   = 3'd4,
    STAT_FULL     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_LOOK,
    ST_CHECK,
    ST_SCAN,
    ST_EVICT,
    ST_FILL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] refs;
    logic [31:0] last_access;
    logic [31:0] arrival;
    logic [15:0] frame;
    logic        valid;
  } entry_t;

endpackage

FILE: hdl/fifo_page_replacement_unit.sv
// fifo page replacement unit: page table in one memory, free frame stack in another
// push: result after the stack write; hit, free-frame miss and zero scan limit: after the table read
// replacement miss: scan below the limit, then evict and fill if a victim is found; one table read per cycle
// one transaction at a time, the next can be taken in the same cycle as the result shows
// after rst a clearing pass writes every table entry invalid, no input taken
// depends on fpru_pkg and fifo_page_replacement_unit_macros.svh
`include "fifo_page_replacement_unit_macros.svh"

module fifo_page_replacement_unit #(
  parameter int PAGES  = fpru_pkg::PAGES_DEF,
  parameter int FRAMES = fpru_pkg::FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // page[5:0], access_time[37:6], frame_value[53:38], zero pad
  input  logic [fpru_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd[0]
  input  logic [0:0]                      s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[2:0], frame[18:3], evicted_page[24:19], fault_total[40:25], zero pad
  output logic [fpru_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpru_pkg::CFG_W-1:0]      cfg_data
);
  import fpru_pkg::*;

  localparam int PW = $clog2(PAGES);
  localparam int CW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES + 1);

  state_t state, state_next;

  entry_t ent_mem [PAGES];
  entry_t ent_rd, ent_wd;
  logic          ent_we, ent_re;
  logic [PW-1:0] ent_wa, ent_ra;

  logic [15:0] free_mem [FRAMES];
  logic [15:0] free_rd;
  logic        free_we, free_re;
  logic [NW-1:0] free_count, fc_dec;

  logic [CFG_W-1:0] pages_in_use;
  logic [CW-1:0]    lim, scan_idx;
  logic             scan_go, pend, found;
  logic [PW-1:0]    pend_idx, best_idx, page_mod, page_q;
  logic [31:0]      best_arr, time_q;
  logic [15:0]      best_frame, fval_q, fault, res_frame;
  logic [5:0]       res_evict;
  status_t          res_status;
  logic             cmd_q, last_q;
  logic [OUT_DATA_W-1:0] m_tdata_q;
  logic             m_tvalid_q;
  logic             out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = m_tvalid_q;
  assign m_tdata   = m_tdata_q;
  assign out_free  = !m_tvalid_q || m_tready;
  assign fc_dec    = free_count - 1'b1;
  assign lim = (CW'(pages_in_use) < CW'(PAGES)) ? CW'(pages_in_use) : CW'(PAGES);

  // page number reduced modulo the table depth
  always_comb begin
    page_mod = '0;
    for (int v = 0; v < 64; v++) begin
      if (s_tdata[5:0] == 6'(v)) page_mod = PW'(v % PAGES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ent_we  = 1'b0;
    ent_re  = 1'b0;
    ent_wa  = page_q;
    ent_ra  = page_q;
    ent_wd  = '0;
    free_we = 1'b0;
    free_re = 1'b0;
    scan_go = 1'b0;
    case (state)
      ST_CLEAR: begin
        ent_we = 1'b1;
        ent_wa = scan_idx[PW-1:0];
        if (scan_idx == CW'(PAGES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = (s_tuser[0] == CMD_PUSH) ? ST_PUSH : ST_LOOK;
      end
      ST_PUSH: begin
        free_we    = (free_count < NW'(FRAMES));
        state_next = ST_OUT;
      end
      ST_LOOK: begin
        ent_re     = 1'b1;
        free_re    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (ent_rd.valid) begin
          ent_we = 1'b1;
          ent_wd = ent_rd;
          ent_wd.last_access = time_q;
          if (ent_rd.refs != '1) ent_wd.refs = ent_rd.refs + 32'd1;
          state_next = ST_OUT;
        end else if (free_count != '0) begin
          ent_we = 1'b1;
          ent_wd = '{refs: 32'd1, last_access: time_q, arrival: time_q,
                     frame: free_rd, valid: 1'b1};
          state_next = ST_OUT;
        end else if (lim == '0) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_go = (scan_idx < lim);
        ent_re  = scan_go;
        ent_ra  = scan_idx[PW-1:0];
        if (!scan_go && !pend) state_next = found ? ST_EVICT : ST_OUT;
      end
      ST_EVICT: begin
        ent_we = 1'b1;
        ent_wa = best_idx;
        ent_wd = '1;
        ent_wd.valid = 1'b0;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        ent_we = 1'b1;
        ent_wd = '{refs: 32'd1, last_access: time_q, arrival: time_q,
                   frame: best_frame, valid: 1'b1};
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_count[FW-1:0]] <= fval_q;
    if (free_re) free_rd <= free_mem[fc_dec[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= PAGES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      pages_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      free_count <= '0;
      fault      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      pend <= (state == ST_SCAN) && scan_go;
      if (m_tvalid_q && m_tready && state != ST_OUT) m_tvalid_q <= 1'b0;
      case (state)
        ST_CLEAR: begin
          scan_idx <= scan_idx + 1'b1;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= s_tuser[0];
            page_q <= page_mod;
            time_q <= s_tdata[37:6];
            fval_q <= s_tdata[53:38];
            last_q <= s_tlast;
          end
        end
        ST_PUSH: begin
          if (free_count < NW'(FRAMES)) begin
            free_count <= free_count + 1'b1;
            res_status <= STAT_PUSHED;
          end else begin
            res_status <= STAT_FULL;
          end
          res_frame <= fval_q;
          res_evict <= '0;
        end
        ST_CHECK: begin
          res_evict <= '0;
          if (ent_rd.valid) begin
            res_status <= STAT_HIT;
            res_frame  <= ent_rd.frame;
          end else begin
            if (fault != '1) fault <= fault + 16'd1;
            if (free_count != '0) begin
              free_count <= fc_dec;
              res_status <= STAT_FREE;
              res_frame  <= free_rd;
            end else begin
              res_status <= STAT_NO_FRAME;
              res_frame  <= '0;
              scan_idx   <= '0;
              found      <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_go) scan_idx <= scan_idx + 1'b1;
          pend_idx <= scan_idx[PW-1:0];
          if (pend && ent_rd.valid && (!found || ent_rd.arrival < best_arr)) begin
            found      <= 1'b1;
            best_idx   <= pend_idx;
            best_arr   <= ent_rd.arrival;
            best_frame <= ent_rd.frame;
          end
        end
        ST_EVICT: begin
          res_status <= STAT_REPLACED;
          res_frame  <= best_frame;
          res_evict  <= 6'(best_idx);
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata_q  <= {7'd0, fault, res_evict, res_frame, res_status};
            m_tvalid_q <= 1'b1;
            if (cmd_q != CMD_PUSH && last_q) fault <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `FPRU_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `FPRU_IMPLIES(a_free_bound, 1'b1, free_count <= NW'(FRAMES), "free stack overflow")
  `FPRU_IMPLIES(a_scan_range, pend, CW'(pend_idx) < lim, "scan beyond limit")
  `FPRU_NEXT(a_result_source, !m_tvalid && state != ST_OUT, !m_tvalid, "result outside out state")

endmodule

FILE: bench/tb_fifo_page_replacement_unit.sv
// self-checking bench for fifo_page_replacement_unit: directed table then random reference strings
// keeps its own page table, free stack and fault total to predict every result transaction
// depends on fpru_pkg and the fifo_page_replacement_unit rtl
module tb_fifo_page_replacement_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fpru_pkg::*;

  localparam int   PAGES       = PAGES_DEF;
  localparam int   FRAMES      = FRAMES_DEF;
  localparam logic CMD_ACCESS  = 1'b0;
  localparam int   QUIET_LIMIT = 2000;
  localparam int   DRAIN_WAIT  = 100;
  localparam int   PHASES      = 7;
  localparam int   PHASE_ITEMS = 236;
  localparam int   DIR_ROWS    = 23;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] frame;
    logic [5:0]  evicted;
    logic [15:0] total;
  } page_result_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [6:0]   cfg;
    logic         cmd;
    logic [5:0]   page;
    logic [31:0]  stamp;
    logic [15:0]  fval;
    logic         last;
    logic         known;
    page_result_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [0:0]            s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  // predictor state
  bit          tbl_valid[PAGES];
  logic [15:0] tbl_frame[PAGES];
  logic [31:0] tbl_arrival[PAGES];
  logic [31:0] tbl_last_access[PAGES];
  logic [31:0] tbl_refs[PAGES];
  logic [15:0] pool[FRAMES];
  int          pool_count;
  logic [15:0] fault_count;
  logic [6:0]  scan_limit;

  page_result_t results_due[$];
  int           errors;
  bit           idle_on;
  int           stall_left;
  int           quiet_cycles;

  dir_row_t directed[DIR_ROWS] = '{
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd5,  32'd100,        16'h0000, 1'b0, 1'b1,
      '{STAT_NO_FRAME, 16'h0000, 6'd0,  16'd1}},
    '{ROW_ITEM, 7'd0,   CMD_PUSH,   6'd0,  32'd0,          16'hFFFF, 1'b0, 1'b1,
      '{STAT_PUSHED,   16'hFFFF, 6'd0,  16'd1}},
    '{ROW_ITEM, 7'd0,   CMD_PUSH,   6'd0,  32'd0,          16'h0000, 1'b0, 1'b1,
      '{STAT_PUSHED,   16'h0000, 6'd0,  16'd1}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd63, 32'hFFFF_FFFF,  16'h0000, 1'b0, 1'b1,
      '{STAT_FREE,     16'h0000, 6'd0,  16'd2}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd0,  32'd0,          16'h0000, 1'b0, 1'b1,
      '{STAT_FREE,     16'hFFFF, 6'd0,  16'd3}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd63, 32'd5,          16'h0000, 1'b1, 1'b1,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd3}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd7,  32'd200,        16'h0000, 1'b0, 1'b1,
      '{STAT_REPLACED, 16'hFFFF, 6'd0,  16'd1}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd0,  32'd200,        16'h0000, 1'b0, 1'b1,
      '{STAT_REPLACED, 16'hFFFF, 6'd7,  16'd2}},
    '{ROW_ITEM, 7'd0,   CMD_PUSH,   6'd0,  32'd0,          16'h1234, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd32, 32'd200,        16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    // equal arrival times: lowest index goes
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd40, 32'd300,        16'h0000, 1'b1, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_CFG,  7'd0,   CMD_ACCESS, 6'd0,  32'd0,          16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd1,  32'd400,        16'h0000, 1'b0, 1'b1,
      '{STAT_NO_FRAME, 16'h0000, 6'd0,  16'd1}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd32, 32'd401,        16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_CFG,  7'd1,   CMD_ACCESS, 6'd0,  32'd0,          16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd2,  32'd500,        16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_CFG,  7'd41,  CMD_ACCESS, 6'd0,  32'd0,          16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd3,  32'd600,        16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_CFG,  7'd127, CMD_ACCESS, 6'd0,  32'd0,          16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd4,  32'h8000_0000,  16'h0000, 1'b1, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    // last mark on a push leaves the total alone
    '{ROW_ITEM, 7'd0,   CMD_PUSH,   6'd0,  32'd0,          16'hA5A5, 1'b1, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd63, 32'd0,          16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}},
    '{ROW_ITEM, 7'd0,   CMD_ACCESS, 6'd10, 32'h5555_5555,  16'h0000, 1'b0, 1'b0,
      '{STAT_HIT,      16'h0000, 6'd0,  16'd0}}
  };

  fifo_page_replacement_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void claim_entry(input int p, input logic [15:0] frame,
                                      input logic [31:0] stamp);
    tbl_valid[p]       = 1'b1;
    tbl_frame[p]       = frame;
    tbl_arrival[p]     = stamp;
    tbl_last_access[p] = stamp;
    tbl_refs[p]        = 32'd1;
  endfunction

  function automatic page_result_t page_lookup(input logic cmd, input logic [5:0] page,
                                               input logic [31:0] stamp,
                                               input logic [15:0] fval, input logic last);
    page_result_t r;
    int           limit;
    int           victim;
    bit           found;
    r      = '{STAT_HIT, 16'h0000, 6'd0, 16'd0};
    victim = 0;
    found  = 1'b0;
    if (cmd == CMD_PUSH) begin
      if (pool_count < FRAMES) begin
        pool[pool_count] = fval;
        pool_count++;
        r.status = STAT_PUSHED;
      end else begin
        r.status = STAT_FULL;
      end
      r.frame = fval;
      r.total = fault_count;
    end else begin
      if (tbl_valid[page]) begin
        tbl_last_access[page] = stamp;
        if (tbl_refs[page] != 32'hFFFF_FFFF) tbl_refs[page]++;
        r.frame  = tbl_frame[page];
        r.status = STAT_HIT;
      end else begin
        if (fault_count != 16'hFFFF) fault_count++;
        if (pool_count > 0) begin
          pool_count--;
          r.frame = pool[pool_count];
          claim_entry(page, r.frame, stamp);
          r.status = STAT_FREE;
        end else begin
          limit = (scan_limit < PAGES) ? scan_limit : PAGES;
          for (int i = 0; i < limit; i++) begin
            if (tbl_valid[i] && (!found || tbl_arrival[i] < tbl_arrival[victim])) begin
              victim = i;
              found  = 1'b1;
            end
          end
          if (found) begin
            r.frame                 = tbl_frame[victim];
            tbl_valid[victim]       = 1'b0;
            tbl_frame[victim]       = 16'hFFFF;
            tbl_arrival[victim]     = 32'hFFFF_FFFF;
            tbl_last_access[victim] = 32'hFFFF_FFFF;
            tbl_refs[victim]        = 32'hFFFF_FFFF;
            claim_entry(page, r.frame, stamp);
            r.evicted = victim[5:0];
            r.status  = STAT_REPLACED;
          end else begin
            r.status = STAT_NO_FRAME;
          end
        end
      end
      r.total = fault_count;
      if (last) fault_count = 16'd0;
    end
    return r;
  endfunction

  task automatic drive_item(input logic cmd, input logic [5:0] page, input logic [31:0] stamp,
                            input logic [15:0] fval, input logic last, input logic known,
                            input page_result_t typed);
    page_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, fval, stamp, page};
    s_tuser  <= cmd;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = page_lookup(cmd, page, stamp, fval, last);
    results_due.push_back(known ? typed : predicted);
  endtask

  task automatic write_pages_in_use(input logic [6:0] value);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    scan_limit = value;
  endtask

  // result sink with bursty stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    page_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $error("result transaction with none expected: m_tdata=%h", m_tdata);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[18:3] !== want.frame) begin
          $error("frame: expected %0d, actual %0d", want.frame, m_tdata[18:3]);
          errors++;
        end
        if (m_tdata[24:19] !== want.evicted) begin
          $error("evicted_page: expected %0d, actual %0d", want.evicted, m_tdata[24:19]);
          errors++;
        end
        if (m_tdata[40:25] !== want.total) begin
          $error("fault_total: expected %0d, actual %0d", want.total, m_tdata[40:25]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    logic [6:0]   phase_piu[PHASES];
    logic [31:0]  now;
    logic [31:0]  stamp;
    logic [5:0]   base;
    int           span;
    int           n;
    int           pick;
    int           phase_items;
    page_result_t none;
    none         = '{STAT_HIT, 16'h0000, 6'd0, 16'd0};
    errors       = 0;
    idle_on      = 1'b1;
    stall_left   = 0;
    quiet_cycles = 0;
    pool_count   = 0;
    fault_count  = 16'd0;
    scan_limit   = PAGES_IN_USE_RST;
    for (int i = 0; i < PAGES; i++) tbl_valid[i] = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_pages_in_use(directed[i].cfg);
      end else begin
        drive_item(directed[i].cmd, directed[i].page, directed[i].stamp, directed[i].fval,
                   directed[i].last, directed[i].known, directed[i].want);
      end
    end

    phase_piu = '{7'd64, 7'd127, 7'($urandom_range(2, 63)), 7'd1,
                  7'($urandom_range(65, 126)), 7'd0, 7'd64};
    now = $urandom();
    for (int ph = 0; ph < PHASES; ph++) begin
      write_pages_in_use(phase_piu[ph]);
      if (ph == PHASES - 1) idle_on = 1'b0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick < 5) begin
          // burst of free frames, long enough to overflow the stack now and then
          n = $urandom_range(1, 20);
          repeat (n) begin
            drive_item(CMD_PUSH, 6'($urandom()), $urandom(), 16'($urandom()),
                       1'($urandom_range(0, 1)), 1'b0, none);
          end
        end else if (pick < 18) begin
          // reference string over a small working set
          n    = $urandom_range(1, 12);
          span = $urandom_range(1, 8);
          base = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
          for (int k = 0; k < n; k++) begin
            now   = now + $urandom_range(0, 3);
            stamp = ($urandom_range(0, 15) == 0) ? $urandom() : now;
            drive_item(CMD_ACCESS, base + 6'($urandom_range(0, span - 1)), stamp,
                       16'($urandom()), k == n - 1, 1'b0, none);
          end
        end else begin
          n = 1;
          drive_item(1'($urandom_range(0, 1)), 6'($urandom()), $urandom(), 16'($urandom()),
                     1'($urandom_range(0, 1)), 1'b0, none);
        end
        phase_items += n;
      end
    end

    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: fifo_page_replacement_unit.f
+incdir+hdl
hdl/fpru_pkg.sv
hdl/fifo_page_replacement_unit.sv
bench/tb_fifo_page_replacement_unit.sv
